>>> hdl/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion wrappers, clocked on aclk, off during reset
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// property that holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cpt_pkg.sv
//------------------------------------------------------------------------------
// cpt_pkg
// widths, types and arithmetic helpers of the circumcircle point test
//------------------------------------------------------------------------------
package cpt_pkg;

    localparam int CW     = 16;            // coordinate width
    localparam int FRAC   = 16;            // fraction bits of the centre
    localparam int LIMW   = 8;             // limit register width
    localparam int DFW    = CW + 1;        // coordinate difference
    localparam int PW     = 2 * DFW;       // product of two differences
    localparam int SW     = PW + 1;        // sum of two products
    localparam int DW     = SW + 1;        // divisor
    localparam int NPW    = DFW + SW;      // difference times squared length
    localparam int NMW    = NPW + 1;       // numerator
    localparam int NW     = NMW + FRAC;    // dividend, one pipeline stage per bit
    localparam int QCL    = 60;            // quotient magnitude clamp exponent
    localparam int MAGW   = QCL + 1;
    localparam int CTRW   = 40;            // centre output width
    localparam int CBW    = CW + FRAC;     // coordinate in centre format
    localparam int CSW    = MAGW + 2;      // centre before saturation
    localparam int DMW    = CTRW + 1;      // distance magnitude
    localparam int SPLIT  = 32;            // multiplier split point
    localparam int HW     = DMW - SPLIT;
    localparam int SQW    = 2 * DMW;
    localparam int R2W    = SQW + 1;
    localparam int RSQW   = 56;
    localparam int RTW    = R2W + 1 - FRAC;

    localparam logic [MAGW-1:0] QCLAMP = {1'b1, {QCL{1'b0}}};
    localparam logic signed [CSW-1:0] CSAT_MAX = {{(CSW-CTRW+1){1'b0}}, {(CTRW-1){1'b1}}};
    localparam logic signed [CSW-1:0] CSAT_MIN = {{(CSW-CTRW+1){1'b1}}, {(CTRW-1){1'b0}}};

    localparam logic [0:0] CFG_FLAT  = 1'b0;
    localparam logic [0:0] CFG_HORIZ = 1'b1;

    typedef enum logic [1:0] {
        SEL_AB,
        SEL_BC,
        SEL_GEN
    } sel_t;

    typedef struct packed {
        sel_t                   sel;
        logic                   degen;
        logic signed [CW-1:0]   xb;
        logic signed [CW-1:0]   yb;
        logic signed [CW-1:0]   px;
        logic signed [CW-1:0]   py;
        logic signed [DFW-1:0]  hsum;
        logic                   neg_x;
        logic                   neg_y;
    } side_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [NW-1:0] w;
    } dstep_t;

    // one restoring step: dividend bits leave at the top, quotient bits enter below
    function automatic dstep_t div_step(input logic [DW-1:0] rem, input logic [NW-1:0] w,
                                        input logic [DW-1:0] md);
        logic [DW:0]   rsh;
        logic [DW+1:0] dif;
        dstep_t        r;
        rsh   = {rem, w[NW-1]};
        dif   = {1'b0, rsh} - {2'b00, md};
        r.rem = dif[DW+1] ? rsh[DW-1:0] : dif[DW-1:0];
        r.w   = {w[NW-2:0], ~dif[DW+1]};
        return r;
    endfunction

    // round half away from zero, clamp the magnitude, apply the sign
    function automatic logic signed [MAGW:0] round_clamp(input logic [DW-1:0] rem,
                                                         input logic [NW-1:0] q,
                                                         input logic [DW-1:0] md,
                                                         input logic neg);
        logic            up;
        logic [NW:0]     qr;
        logic [MAGW-1:0] big;
        up  = ({rem, 1'b0} >= {1'b0, md});
        qr  = {1'b0, q} + (NW+1)'(up);
        big = (qr > (NW+1)'(QCLAMP)) ? QCLAMP : qr[MAGW-1:0];
        return neg ? -signed'({1'b0, big}) : signed'({1'b0, big});
    endfunction

    function automatic logic signed [CTRW-1:0] sat_ctr(input logic signed [CSW-1:0] v);
        logic signed [CTRW-1:0] r;
        if (v > CSAT_MAX) begin
            r = CSAT_MAX[CTRW-1:0];
        end else if (v < CSAT_MIN) begin
            r = CSAT_MIN[CTRW-1:0];
        end else begin
            r = v[CTRW-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/circumcircle_point_test_top.sv
//------------------------------------------------------------------------------
// circumcircle_point_test_top
// Takes one triangle and query point per beat and returns one result beat for
// each, one beat per cycle sustained. The restoring divider forms one quotient
// bit per stage over 69 stages, with five stages ahead of it and seven behind.
// The whole pipeline holds while a result waits on m_ready, so nothing is lost
// or repeated. Configuration takes effect on the next accepted beat; the user
// must write it only while the pipeline is empty, as the block does not check.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module circumcircle_point_test_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [cpt_pkg::LIMW-1:0]            cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [cpt_pkg::CW-1:0]       s_a_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_a_y,
    input  logic signed [cpt_pkg::CW-1:0]       s_b_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_b_y,
    input  logic signed [cpt_pkg::CW-1:0]       s_c_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_c_y,
    input  logic signed [cpt_pkg::CW-1:0]       s_point_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_point_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_inside_res,
    output logic                                m_left_of_point,
    output logic                                m_degenerate,
    output logic signed [cpt_pkg::CTRW-1:0]     m_center_x,
    output logic signed [cpt_pkg::CTRW-1:0]     m_center_y,
    output logic [cpt_pkg::RSQW-1:0]            m_radius_sq
);
    import cpt_pkg::*;

    logic en;

    logic [LIMW-1:0] flat_limit_reg;
    logic [LIMW-1:0] horiz_limit_reg;

    // stage 1
    logic signed [DFW-1:0] ux_next, uy_next, vx_next, vy_next;
    logic signed [DFW-1:0] f1_next, f2_next, f3_next, f4_next;
    logic [DFW-1:0]        abs_ab, abs_ac, abs_bc;
    side_t                 s1_side_next;
    logic                  v1_reg;
    logic signed [DFW-1:0] ux1_reg, uy1_reg, vx1_reg, vy1_reg;
    logic signed [DFW-1:0] f1_reg, f2_reg, f3_reg, f4_reg;
    side_t                 s1_side_reg;

    // stage 2
    logic                  v2_reg;
    logic signed [PW-1:0]  pc1_reg, pc2_reg, pux_reg, puy_reg, pvx_reg, pvy_reg;
    logic signed [PW-1:0]  pa_reg, pb_reg;
    logic signed [DFW-1:0] ux2_reg, uy2_reg, vx2_reg, vy2_reg, f2b_reg;
    side_t                 s2_side_reg;

    // stage 3
    logic signed [SW-1:0]  cross_next;
    logic signed [DW-1:0]  den_next;
    side_t                 s3_side_next;
    logic                  v3_reg;
    logic signed [DW-1:0]  den3_reg;
    logic signed [SW-1:0]  uu_reg, vv_reg, snum3_reg;
    logic signed [DFW:0]   sdiv3_reg;
    logic signed [DFW-1:0] ux3_reg, uy3_reg, vx3_reg, vy3_reg;
    side_t                 s3_side_reg;

    // stage 4
    logic                  v4_reg;
    logic signed [NPW-1:0] mvu_reg, muv_reg, mxv_reg, mxu_reg;
    logic signed [DW-1:0]  den4_reg;
    logic signed [SW-1:0]  snum4_reg;
    logic signed [DFW:0]   sdiv4_reg;
    side_t                 s4_side_reg;

    // stage 5 and divider
    logic signed [NMW-1:0] nx_next, ny_next;
    logic signed [DW-1:0]  d_next;
    logic [NMW-1:0]        nxm_next, nym_next;
    side_t                 s5_side_next;
    logic [NW:0]           dv_reg;
    logic [DW-1:0]         xr_reg [0:NW];
    logic [DW-1:0]         yr_reg [0:NW];
    logic [NW-1:0]         xw_reg [0:NW];
    logic [NW-1:0]         yw_reg [0:NW];
    logic [DW-1:0]         md_reg [0:NW];
    side_t                 dside_reg [0:NW];
    dstep_t                xs_next [1:NW];
    dstep_t                ys_next [1:NW];

    // stage 6 to output
    logic                  v6_reg, v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic signed [MAGW:0]  qsx_reg, qsy_reg;
    side_t                 s6_side_reg, s7_side_reg, s8_side_reg, s9_side_reg;
    side_t                 s10_side_reg, s11_side_reg;
    logic signed [CBW-1:0] xbase7, ybase7;
    logic signed [CSW-1:0] csx_next, csy_next;
    logic signed [CTRW-1:0] cx7_reg, cy7_reg, cx8_reg, cy8_reg, cx9_reg, cy9_reg;
    logic signed [CTRW-1:0] cx10_reg, cy10_reg, cx11_reg, cy11_reg;
    logic signed [DMW:0]   dist_next [0:3];
    logic [DMW-1:0]        mag_reg [0:3];
    logic                  pos8_reg, pos9_reg, pos10_reg, pos11_reg;
    logic [2*HW-1:0]       hh_reg [0:3];
    logic [DMW-1:0]        hl_reg [0:3];
    logic [2*SPLIT-1:0]    ll_reg [0:3];
    logic [SQW-1:0]        sq_reg [0:3];
    logic [R2W-1:0]        r2_reg, p2_reg;
    logic [SQW-1:0]        sqp_reg;
    logic [R2W:0]          rt_next;
    logic [RTW-1:0]        rsh_next;

    logic                  m_valid_reg;
    logic                  inside_reg, left_reg, degen_reg;
    logic signed [CTRW-1:0] cx_out_reg, cy_out_reg;
    logic [RSQW-1:0]       rsq_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flat_limit_reg  <= LIMW'(1);
            horiz_limit_reg <= LIMW'(5);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FLAT:  flat_limit_reg  <= cfg_data;
                CFG_HORIZ: horiz_limit_reg <= cfg_data;
                default:   flat_limit_reg  <= flat_limit_reg;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            dv_reg      <= '0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            v10_reg     <= 1'b0;
            v11_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            dv_reg      <= {dv_reg[NW-1:0], v4_reg};
            v6_reg      <= dv_reg[NW];
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            v9_reg      <= v8_reg;
            v10_reg     <= v9_reg;
            v11_reg     <= v10_reg;
            m_valid_reg <= v11_reg;
        end
    end

    // stage 1: differences, limits and case selection
    always_comb begin
        ux_next = DFW'(s_a_x) - DFW'(s_b_x);
        uy_next = DFW'(s_a_y) - DFW'(s_b_y);
        vx_next = DFW'(s_c_x) - DFW'(s_b_x);
        vy_next = DFW'(s_c_y) - DFW'(s_b_y);
        abs_ab  = uy_next[DFW-1] ? DFW'(-uy_next) : DFW'(uy_next);
        abs_bc  = vy_next[DFW-1] ? DFW'(-vy_next) : DFW'(vy_next);
        abs_ac  = (s_a_y < s_c_y) ? DFW'(DFW'(s_c_y) - DFW'(s_a_y))
                                  : DFW'(DFW'(s_a_y) - DFW'(s_c_y));
        s1_side_next.degen = (abs_ab < DFW'(flat_limit_reg)) && (abs_ac < DFW'(flat_limit_reg));
        priority if (abs_ab < DFW'(horiz_limit_reg)) begin
            s1_side_next.sel = SEL_AB;
        end else if (abs_bc < DFW'(horiz_limit_reg)) begin
            s1_side_next.sel = SEL_BC;
        end else begin
            s1_side_next.sel = SEL_GEN;
        end
        if (s1_side_next.sel == SEL_AB) begin
            f1_next = DFW'(s_b_y) + DFW'(s_c_y);
            f2_next = vy_next;
            f3_next = vx_next;
            f4_next = DFW'(s_a_x) - DFW'(s_c_x);
            s1_side_next.hsum = DFW'(s_a_x) + DFW'(s_b_x);
        end else begin
            f1_next = DFW'(s_a_y) + DFW'(s_b_y);
            f2_next = -uy_next;
            f3_next = -ux_next;
            f4_next = DFW'(s_c_x) - DFW'(s_a_x);
            s1_side_next.hsum = DFW'(s_b_x) + DFW'(s_c_x);
        end
        s1_side_next.xb    = s_b_x;
        s1_side_next.yb    = s_b_y;
        s1_side_next.px    = s_point_x;
        s1_side_next.py    = s_point_y;
        s1_side_next.neg_x = 1'b0;
        s1_side_next.neg_y = 1'b0;
    end

    // stage 3: divisors, squared lengths and degenerate cases
    always_comb begin
        cross_next   = SW'(pc1_reg) - SW'(pc2_reg);
        den_next     = {cross_next, 1'b0};
        s3_side_next = s2_side_reg;
        unique case (s2_side_reg.sel)
            SEL_AB, SEL_BC: begin
                if (f2b_reg == '0) begin
                    s3_side_next.degen = 1'b1;
                end
            end
            default: begin
                if (uy2_reg == '0 || vy2_reg == '0 || den_next == '0) begin
                    s3_side_next.degen = 1'b1;
                end
            end
        endcase
    end

    // stage 5: numerators, magnitudes and signs
    always_comb begin
        s5_side_next = s4_side_reg;
        if (s4_side_reg.sel == SEL_GEN) begin
            nx_next = NMW'(mvu_reg) - NMW'(muv_reg);
            ny_next = NMW'(mxv_reg) - NMW'(mxu_reg);
            d_next  = den4_reg;
        end else begin
            nx_next = '0;
            ny_next = NMW'(snum4_reg);
            d_next  = DW'(sdiv4_reg);
        end
        nxm_next = nx_next[NMW-1] ? NMW'(-nx_next) : NMW'(nx_next);
        nym_next = ny_next[NMW-1] ? NMW'(-ny_next) : NMW'(ny_next);
        s5_side_next.neg_x = nx_next[NMW-1] ^ d_next[DW-1];
        s5_side_next.neg_y = ny_next[NMW-1] ^ d_next[DW-1];
    end

    // divider steps
    always_comb begin
        for (int k = 1; k <= NW; k++) begin
            xs_next[k] = div_step(xr_reg[k-1], xw_reg[k-1], md_reg[k-1]);
            ys_next[k] = div_step(yr_reg[k-1], yw_reg[k-1], md_reg[k-1]);
        end
    end

    // stage 7: centre
    always_comb begin
        xbase7 = signed'({s6_side_reg.xb, {FRAC{1'b0}}});
        ybase7 = signed'({s6_side_reg.yb, {FRAC{1'b0}}});
        if (s6_side_reg.sel == SEL_GEN) begin
            csx_next = CSW'(xbase7) + CSW'(qsx_reg);
            csy_next = CSW'(ybase7) + CSW'(qsy_reg);
        end else begin
            csx_next = CSW'(s6_side_reg.hsum) <<< (FRAC - 1);
            csy_next = CSW'(qsy_reg);
        end
    end

    // stage 8: distances to b and to the point
    always_comb begin
        dist_next[0] = (DMW+1)'(signed'({s7_side_reg.xb, {FRAC{1'b0}}})) - (DMW+1)'(cx7_reg);
        dist_next[1] = (DMW+1)'(signed'({s7_side_reg.yb, {FRAC{1'b0}}})) - (DMW+1)'(cy7_reg);
        dist_next[2] = (DMW+1)'(signed'({s7_side_reg.px, {FRAC{1'b0}}})) - (DMW+1)'(cx7_reg);
        dist_next[3] = (DMW+1)'(signed'({s7_side_reg.py, {FRAC{1'b0}}})) - (DMW+1)'(cy7_reg);
    end

    // output stage: radius rounding
    always_comb begin
        rt_next  = (R2W+1)'(r2_reg) + ((R2W+1)'(1) << (FRAC - 1));
        rsh_next = rt_next[R2W:FRAC];
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            ux1_reg     <= ux_next;
            uy1_reg     <= uy_next;
            vx1_reg     <= vx_next;
            vy1_reg     <= vy_next;
            f1_reg      <= f1_next;
            f2_reg      <= f2_next;
            f3_reg      <= f3_next;
            f4_reg      <= f4_next;
            s1_side_reg <= s1_side_next;

            pc1_reg     <= ux1_reg * vy1_reg;
            pc2_reg     <= uy1_reg * vx1_reg;
            pux_reg     <= ux1_reg * ux1_reg;
            puy_reg     <= uy1_reg * uy1_reg;
            pvx_reg     <= vx1_reg * vx1_reg;
            pvy_reg     <= vy1_reg * vy1_reg;
            pa_reg      <= f1_reg * f2_reg;
            pb_reg      <= f3_reg * f4_reg;
            ux2_reg     <= ux1_reg;
            uy2_reg     <= uy1_reg;
            vx2_reg     <= vx1_reg;
            vy2_reg     <= vy1_reg;
            f2b_reg     <= f2_reg;
            s2_side_reg <= s1_side_reg;

            den3_reg    <= den_next;
            uu_reg      <= SW'(pux_reg) + SW'(puy_reg);
            vv_reg      <= SW'(pvx_reg) + SW'(pvy_reg);
            snum3_reg   <= SW'(pa_reg) - SW'(pb_reg);
            sdiv3_reg   <= {f2b_reg, 1'b0};
            ux3_reg     <= ux2_reg;
            uy3_reg     <= uy2_reg;
            vx3_reg     <= vx2_reg;
            vy3_reg     <= vy2_reg;
            s3_side_reg <= s3_side_next;

            mvu_reg     <= vy3_reg * uu_reg;
            muv_reg     <= uy3_reg * vv_reg;
            mxv_reg     <= ux3_reg * vv_reg;
            mxu_reg     <= vx3_reg * uu_reg;
            den4_reg    <= den3_reg;
            snum4_reg   <= snum3_reg;
            sdiv4_reg   <= sdiv3_reg;
            s4_side_reg <= s3_side_reg;

            xr_reg[0]    <= '0;
            yr_reg[0]    <= '0;
            xw_reg[0]    <= {nxm_next, {FRAC{1'b0}}};
            yw_reg[0]    <= {nym_next, {FRAC{1'b0}}};
            md_reg[0]    <= d_next[DW-1] ? DW'(-d_next) : DW'(d_next);
            dside_reg[0] <= s5_side_next;
            for (int k = 1; k <= NW; k++) begin
                xr_reg[k]    <= xs_next[k].rem;
                xw_reg[k]    <= xs_next[k].w;
                yr_reg[k]    <= ys_next[k].rem;
                yw_reg[k]    <= ys_next[k].w;
                md_reg[k]    <= md_reg[k-1];
                dside_reg[k] <= dside_reg[k-1];
            end

            qsx_reg     <= round_clamp(xr_reg[NW], xw_reg[NW], md_reg[NW],
                                       dside_reg[NW].neg_x);
            qsy_reg     <= round_clamp(yr_reg[NW], yw_reg[NW], md_reg[NW],
                                       dside_reg[NW].neg_y);
            s6_side_reg <= dside_reg[NW];

            cx7_reg     <= sat_ctr(csx_next);
            cy7_reg     <= sat_ctr(csy_next);
            s7_side_reg <= s6_side_reg;

            for (int i = 0; i < 4; i++) begin
                mag_reg[i] <= dist_next[i][DMW] ? DMW'(-dist_next[i]) : DMW'(dist_next[i]);
            end
            pos8_reg    <= !dist_next[2][DMW] && (dist_next[2] != '0);
            cx8_reg     <= cx7_reg;
            cy8_reg     <= cy7_reg;
            s8_side_reg <= s7_side_reg;

            for (int i = 0; i < 4; i++) begin
                hh_reg[i] <= mag_reg[i][DMW-1:SPLIT] * mag_reg[i][DMW-1:SPLIT];
                hl_reg[i] <= mag_reg[i][DMW-1:SPLIT] * mag_reg[i][SPLIT-1:0];
                ll_reg[i] <= mag_reg[i][SPLIT-1:0] * mag_reg[i][SPLIT-1:0];
            end
            pos9_reg    <= pos8_reg;
            cx9_reg     <= cx8_reg;
            cy9_reg     <= cy8_reg;
            s9_side_reg <= s8_side_reg;

            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= (SQW'(hh_reg[i]) << (2 * SPLIT))
                           + (SQW'(hl_reg[i]) << (SPLIT + 1))
                           + SQW'(ll_reg[i]);
            end
            pos10_reg    <= pos9_reg;
            cx10_reg     <= cx9_reg;
            cy10_reg     <= cy9_reg;
            s10_side_reg <= s9_side_reg;

            r2_reg       <= R2W'(sq_reg[0]) + R2W'(sq_reg[1]);
            p2_reg       <= R2W'(sq_reg[2]) + R2W'(sq_reg[3]);
            sqp_reg      <= sq_reg[2];
            pos11_reg    <= pos10_reg;
            cx11_reg     <= cx10_reg;
            cy11_reg     <= cy10_reg;
            s11_side_reg <= s10_side_reg;

            if (s11_side_reg.degen) begin
                inside_reg <= 1'b0;
                left_reg   <= 1'b0;
                degen_reg  <= 1'b1;
                cx_out_reg <= '0;
                cy_out_reg <= '0;
                rsq_reg    <= '0;
            end else begin
                inside_reg <= !(r2_reg < p2_reg);
                left_reg   <= pos11_reg && (r2_reg < R2W'(sqp_reg));
                degen_reg  <= 1'b0;
                cx_out_reg <= cx11_reg;
                cy_out_reg <= cy11_reg;
                rsq_reg    <= (rsh_next[RTW-1:RSQW] != '0) ? {RSQW{1'b1}}
                                                          : rsh_next[RSQW-1:0];
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_inside_res    = inside_reg;
    assign m_left_of_point = left_reg;
    assign m_degenerate    = degen_reg;
    assign m_center_x      = cx_out_reg;
    assign m_center_y      = cy_out_reg;
    assign m_radius_sq     = rsq_reg;

    `ASSERT_SAME(a_degen_clear, m_valid && m_degenerate, m_center_x == '0 && m_center_y == '0 && m_radius_sq == '0 && !m_inside_res && !m_left_of_point, "degenerate result carries data")
    `ASSERT_SAME(a_left_outside, m_valid && m_left_of_point, !m_inside_res, "circle left of point but point inside")
    `ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, $stable(v11_reg) && $stable(dv_reg), "pipeline moved during stall")

endmodule

>>> verif/circumcircle_point_test_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// circumcircle_point_test_checker
// Watches the query and result channels of the circumcircle point test. Every
// accepted query is run through an exact wide-integer circumcentre predictor
// that follows the current limit registers. The predicted result beats are
// queued and compared field by field with the beats the block returns.
//------------------------------------------------------------------------------
module circumcircle_point_test_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [cpt_pkg::LIMW-1:0]            cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [cpt_pkg::CW-1:0]       s_a_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_a_y,
    input  logic signed [cpt_pkg::CW-1:0]       s_b_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_b_y,
    input  logic signed [cpt_pkg::CW-1:0]       s_c_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_c_y,
    input  logic signed [cpt_pkg::CW-1:0]       s_point_x,
    input  logic signed [cpt_pkg::CW-1:0]       s_point_y,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_inside_res,
    input  logic                                m_left_of_point,
    input  logic                                m_degenerate,
    input  logic signed [cpt_pkg::CTRW-1:0]     m_center_x,
    input  logic signed [cpt_pkg::CTRW-1:0]     m_center_y,
    input  logic [cpt_pkg::RSQW-1:0]            m_radius_sq,
    output int                                  fail_count,
    output int                                  circles_pending,
    output int                                  circles_seen,
    output int                                  degenerate_seen
);
    import cpt_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic              in_circle;
        logic              left;
        logic              degen;
        logic [CTRW-1:0]   cx;
        logic [CTRW-1:0]   cy;
        logic [RSQW-1:0]   rsq;
    } circle_beat_t;

    localparam wide_t ONE      = wide_t'(1) <<< FRAC;
    localparam wide_t CTR_MAX  = (wide_t'(1) <<< (CTRW - 1)) - 1;
    localparam wide_t CTR_MIN  = -(wide_t'(1) <<< (CTRW - 1));
    localparam wide_t RSQ_TOP  = (wide_t'(1) <<< RSQW) - 1;
    localparam wide_t MAG_TOP  = wide_t'(1) <<< QCL;
    localparam int    EXP_DEPTH = 256;

    logic [LIMW-1:0] flat_lim;
    logic [LIMW-1:0] horiz_lim;
    circle_beat_t    circle_mem [0:EXP_DEPTH-1];
    int              wr_count;
    int              rd_count;

    function automatic wide_t mag(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // n * 2^FRAC / d, nearest with ties away from zero, magnitude clamped
    function automatic wide_t frac_quot(input wide_t n, input wide_t d);
        wide_t q;
        wide_t rm;
        wide_t md;
        md = mag(d);
        q  = (mag(n) <<< FRAC) / md;
        rm = (mag(n) <<< FRAC) % md;
        if (rm >= md - rm) begin
            q = q + 1;
        end
        if (q > MAG_TOP) begin
            q = MAG_TOP;
        end
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic wide_t sat_centre(input wide_t v);
        return (v > CTR_MAX) ? CTR_MAX : ((v < CTR_MIN) ? CTR_MIN : v);
    endfunction

    function automatic circle_beat_t circle_predict(input wide_t xa, input wide_t ya,
                                                    input wide_t xb, input wide_t yb,
                                                    input wide_t xc, input wide_t yc,
                                                    input wide_t px, input wide_t py);
        circle_beat_t r;
        wide_t fl;
        wide_t hl;
        wide_t cx;
        wide_t cy;
        wide_t ux;
        wide_t uy;
        wide_t vx;
        wide_t vy;
        wide_t den;
        wide_t uu;
        wide_t vv;
        wide_t dx;
        wide_t dy;
        wide_t r2;
        wide_t p2;
        wide_t t;
        r  = '0;
        fl = wide_t'({1'b0, flat_lim});
        hl = wide_t'({1'b0, horiz_lim});
        if (mag(ya - yb) < fl && mag(ya - yc) < fl) begin
            r.degen = 1'b1;
            return r;
        end
        if (mag(yb - ya) < hl) begin
            if (yc == yb) begin
                r.degen = 1'b1;
                return r;
            end
            cx = (xa + xb) * (ONE / 2);
            cy = frac_quot((yb + yc) * (yc - yb) - (xc - xb) * (xa - xc), 2 * (yc - yb));
        end else if (mag(yc - yb) < hl) begin
            if (yb == ya) begin
                r.degen = 1'b1;
                return r;
            end
            cx = (xb + xc) * (ONE / 2);
            cy = frac_quot((ya + yb) * (yb - ya) - (xb - xa) * (xc - xa), 2 * (yb - ya));
        end else begin
            ux  = xa - xb;
            uy  = ya - yb;
            vx  = xc - xb;
            vy  = yc - yb;
            den = 2 * (ux * vy - uy * vx);
            uu  = ux * ux + uy * uy;
            vv  = vx * vx + vy * vy;
            if (uy == 0 || vy == 0 || den == 0) begin
                r.degen = 1'b1;
                return r;
            end
            cx = xb * ONE + frac_quot(vy * uu - uy * vv, den);
            cy = yb * ONE + frac_quot(ux * vv - vx * uu, den);
        end
        cx = sat_centre(cx);
        cy = sat_centre(cy);
        dx = xb * ONE - cx;
        dy = yb * ONE - cy;
        r2 = dx * dx + dy * dy;
        dx = px * ONE - cx;
        dy = py * ONE - cy;
        p2 = dx * dx + dy * dy;
        t  = (r2 + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
        if (t > RSQ_TOP) begin
            t = RSQ_TOP;
        end
        r.in_circle = !(r2 < p2);
        r.left      = (dx > 0) && (r2 < dx * dx);
        r.cx        = cx[CTRW-1:0];
        r.cy        = cy[CTRW-1:0];
        r.rsq       = t[RSQW-1:0];
        return r;
    endfunction

    assign circles_pending = wr_count - rd_count;

    always @(posedge aclk) begin
        circle_beat_t exp_beat;
        circle_beat_t got;
        if (!aresetn) begin
            flat_lim        <= 8'd1;
            horiz_lim       <= 8'd5;
            fail_count      <= 0;
            circles_seen    <= 0;
            degenerate_seen <= 0;
            wr_count        <= 0;
            rd_count        <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FLAT:  flat_lim  <= cfg_data;
                    CFG_HORIZ: horiz_lim <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                circle_mem[wr_count % EXP_DEPTH] <=
                    circle_predict(s_a_x, s_a_y, s_b_x, s_b_y,
                                   s_c_x, s_c_y, s_point_x, s_point_y);
                wr_count <= wr_count + 1;
            end
            if (m_valid && m_ready) begin
                got = {m_inside_res, m_left_of_point, m_degenerate,
                       m_center_x, m_center_y, m_radius_sq};
                circles_seen    <= circles_seen + 1;
                degenerate_seen <= degenerate_seen + int'(m_degenerate);
                if (wr_count == rd_count) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected result beat %p", $realtime, got);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    exp_beat = circle_mem[rd_count % EXP_DEPTH];
                    rd_count <= rd_count + 1;
                    if (got !== exp_beat) begin
                        if (fail_count < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  in_circle exp %0d got %0d",
                                     exp_beat.in_circle, got.in_circle);
                            $display("  left     exp %0d got %0d", exp_beat.left, got.left);
                            $display("  degen    exp %0d got %0d", exp_beat.degen, got.degen);
                            $display("  centre_x exp %0d got %0d",
                                     $signed(exp_beat.cx), $signed(got.cx));
                            $display("  centre_y exp %0d got %0d",
                                     $signed(exp_beat.cy), $signed(got.cy));
                            $display("  rad_sq   exp %0d got %0d", exp_beat.rsq, got.rsq);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/circumcircle_point_test_top_test.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// circumcircle_point_test_top_test
// Drives triangles and query points into the circumcircle point test with
// random gaps and result stalls, under several limit register settings, and
// lets the checker compare every result beat with its own prediction.
//------------------------------------------------------------------------------
module circumcircle_point_test_top_test;
    import cpt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_index = CFG_FLAT;
    logic [LIMW-1:0]        cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [CW-1:0]   s_a_x = '0;
    logic signed [CW-1:0]   s_a_y = '0;
    logic signed [CW-1:0]   s_b_x = '0;
    logic signed [CW-1:0]   s_b_y = '0;
    logic signed [CW-1:0]   s_c_x = '0;
    logic signed [CW-1:0]   s_c_y = '0;
    logic signed [CW-1:0]   s_point_x = '0;
    logic signed [CW-1:0]   s_point_y = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_inside_res;
    logic                   m_left_of_point;
    logic                   m_degenerate;
    logic signed [CTRW-1:0] m_center_x;
    logic signed [CTRW-1:0] m_center_y;
    logic [RSQW-1:0]        m_radius_sq;

    int fail_count;
    int circles_pending;
    int circles_seen;
    int degenerate_seen;
    int cycle_count = 0;
    int queries_sent = 0;
    bit no_gaps = 1'b0;

    always #10 aclk = ~aclk;

    circumcircle_point_test_top i_dut (.*);

    circumcircle_point_test_checker i_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("circumcircle_point_test_top verification failed");
            $finish;
        end
    end

    // result side stalls
    initial begin
        int stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    task automatic send_query(input int ax, input int ay, input int bx, input int by,
                              input int cx, input int cy, input int px, input int py);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_a_x     <= CW'(ax);
        s_a_y     <= CW'(ay);
        s_b_x     <= CW'(bx);
        s_b_y     <= CW'(by);
        s_c_x     <= CW'(cx);
        s_c_y     <= CW'(cy);
        s_point_x <= CW'(px);
        s_point_y <= CW'(py);
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        queries_sent++;
        @(negedge aclk);
    endtask

    function automatic int rnd_coord(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_random_query();
        int kind;
        int span;
        int ax, ay, bx, by, cx, cy, px, py;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 1) != 0) ? 200 : 32767;
        ax = rnd_coord(span);
        ay = rnd_coord(span);
        bx = rnd_coord(span);
        by = rnd_coord(span);
        cx = rnd_coord(span);
        cy = rnd_coord(span);
        px = rnd_coord(span);
        py = rnd_coord(span);
        case (kind)
            0: begin
                ax = rnd_coord(32767); ay = rnd_coord(32767); bx = rnd_coord(32767);
                by = rnd_coord(32767); cx = rnd_coord(32767); cy = rnd_coord(32767);
                px = rnd_coord(32767); py = rnd_coord(32767);
            end
            1: by = ay + rnd_coord(6);
            2: cy = by + rnd_coord(6);
            3: begin
                by = ay + rnd_coord(3);
                cy = ay + rnd_coord(3);
            end
            4: begin
                bx = ax + rnd_coord(100);
                by = ay + rnd_coord(100);
                cx = 2 * bx - ax;
                cy = 2 * by - ay;
            end
            5: begin
                bx = ax + 1000;
                by = ay + 1000;
                cx = ax + 2001;
                cy = ay + 2000;
            end
            6: begin
                px = ax;
                py = ay;
            end
            7: begin
                px = 32767;
                py = cy;
            end
            default: ;
        endcase
        send_query(ax, ay, bx, by, cx, cy, px, py);
    endtask

    task automatic drain_pipeline();
        while (circles_pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [0:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= LIMW'(value);
        @(negedge aclk);
    endtask

    initial begin
        int limits[6][2] = '{'{0, 0}, '{255, 255}, '{0, 255}, '{255, 0}, '{3, 10}, '{-1, -1}};
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners under the reset limits
        send_query(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_query(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
        send_query(0, 0, 0, 0, 0, 0, 0, 0);
        send_query(-32768, 5, 32767, 5, 0, 5, 0, 0);
        send_query(0, 0, 10, 2, 20, 2, 1, 1);
        send_query(0, 0, 10, 0, 20, 2, 1, 1);
        send_query(0, 0, 10, 3, 5, 40, 5, 1);
        send_query(0, 40, 10, 3, 20, 5, 10, 20);
        send_query(0, 0, 10, 10, 20, 20, 5, 5);
        send_query(0, 0, 1000, 1000, 2001, 2000, 32767, 0);
        send_query(-32768, -32768, 0, 0, 32767, 32766, -32768, 32767);
        send_query(0, 0, 100, 50, 30, 200, 0, 0);
        send_query(0, 0, 100, 50, 30, 200, 32767, 60);
        send_query(-5, -100, 7, 100, 300, 9, -32768, 32767);
        send_query(1, 100, 3, 300, 2, -300, 2, 0);
        send_query(32767, 32767, -32768, -32767, 0, 32767, 32767, 32767);
        for (int i = 0; i < 60; i++) send_random_query();
        s_valid <= 1'b0;
        drain_pipeline();

        for (int phase = 0; phase < 6; phase++) begin
            if (limits[phase][0] < 0) begin
                write_limit(CFG_FLAT, $urandom_range(0, 255));
                write_limit(CFG_HORIZ, $urandom_range(0, 255));
            end else begin
                write_limit(CFG_FLAT, limits[phase][0]);
                write_limit(CFG_HORIZ, limits[phase][1]);
            end
            cfg_we <= 1'b0;
            no_gaps = (phase % 3) == 1;
            for (int i = 0; i < 70; i++) send_random_query();
            no_gaps = 1'b0;
            s_valid <= 1'b0;
            drain_pipeline();
        end

        $display("%0d queries over seven limit settings, %0d results, %0d degenerate",
                 queries_sent, circles_seen, degenerate_seen);
        if (fail_count == 0) begin
            $display("circumcircle_point_test_top verification clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("circumcircle_point_test_top verification failed");
        end
        $finish;
    end

endmodule
